### sv/grd_pkg.sv
package grd_pkg;

  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_SCREEN_HEIGHT = 480;
  localparam int DEF_GRID_DIM      = 32;

  localparam int MAP_DEPTH = 1024;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int CELL_W    = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

  localparam int DIV_W = 33;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLR,
    CMD_WRITE,
    CMD_LOAD,
    CMD_MUL_X,
    CMD_RAY_X,
    CMD_MUL_Y,
    CMD_RAY_Y,
    CMD_DIV_X,
    CMD_DX_SET,
    CMD_DIV_Y,
    CMD_DY_SET,
    CMD_MUL_SX,
    CMD_SX_SET,
    CMD_MUL_SY,
    CMD_SY_SET,
    CMD_STEP,
    CMD_CHECK,
    CMD_LINE_DIV,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic is_cast;
    logic clr_last;
    logic div_done;
    logic cam_out;
    logic leave;
    logic hit_bit;
    logic steps_done;
    logic perp_zero;
    logic out_free;
  } dp_status_t;

endpackage

### sv/grd_div.sv
module grd_div import grd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-2:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-2:0] rem_r;
  logic [DIV_W-2:0] den_r;
  logic [DIV_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W-1:0] rem_sh;
  logic [DIV_W-1:0] diff;
  logic             take;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    take   = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[DIV_W-2:0] : rem_sh[DIV_W-2:0];
      quo_r <= {quo_r[DIV_W-2:0], take};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### sv/grd_dp.sv
module grd_dp import grd_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int GRID_DIM      = DEF_GRID_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output dp_status_t            status,
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int STEP_LIMIT = 2 * GRID_DIM + 2;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
  localparam int HALF_H     = SCREEN_HEIGHT / 2;
  localparam int REST_H     = SCREEN_HEIGHT - HALF_H;
  localparam logic [CELL_W:0] GD      = (CELL_W + 1)'(GRID_DIM);
  localparam logic [CELL_W:0] GD_LAST = (CELL_W + 1)'(GRID_DIM - 1);
  // Rounded-up reciprocal of the screen width, scaled so that the camera
  // quotient comes out exact for every 10-bit column.
  localparam logic [36:0] CAM_K =
    37'(((64'd1 << 37) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  logic [20:0]        pos_x_r, pos_y_r;
  logic signed [18:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  logic [9:0]          col_r;
  logic signed [27:0]  cam_r;
  logic signed [29:0]  ray_x_r, ray_y_r;
  logic [31:0]         dx_r, dy_r;
  logic [39:0]         side_x_r, side_y_r, perp_r;
  logic [CELL_W-1:0]   mx_r, my_r;
  logic                side_r, leave_r, hit_r;
  logic [STEP_W-1:0]   steps_r;
  logic signed [52:0]  prod_r;
  logic                map_mem [MAP_DEPTH];
  logic                map_rd_r;
  logic [MAP_AW-1:0]   clr_addr_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                out_user_r;

  logic [9:0]          in_col;
  logic [CELL_W-1:0]   in_cx, in_cy;
  logic                in_wall;
  logic [46:0]         cam_prod;
  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_num, div_quo;
  logic [DIV_W-2:0]    div_den;
  logic signed [19:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [52:0]  prod_adj;
  logic signed [29:0]  ray_new;
  logic signed [18:0]  dir_sel;
  logic [29:0]         mag_x, mag_y, mag_sel;
  logic [31:0]         delta_new;
  logic [16:0]         frac_x, frac_y;
  logic                take_x, step_leave;
  logic [CELL_W-1:0]   nx, ny;
  logic [MAP_AW-1:0]   rd_addr, wr_addr;
  logic                wr_en, wr_bit;
  logic [23:0]         perp_sat;
  logic [31:0]         line;
  logic [30:0]         half, start_d, end_s;
  logic [9:0]          row_top, row_bot;

  assign in_col  = in_tdata[9:0];
  assign in_cx   = in_tdata[14:10];
  assign in_cy   = in_tdata[19:15];
  assign in_wall = in_tdata[20];

  assign cam_prod = {37'b0, in_col} * {10'b0, CAM_K};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      dir_x_r   <= 19'sd65536;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= 19'sd43253;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POS_X:   pos_x_r   <= cfg_wdata;
        REG_POS_Y:   pos_y_r   <= cfg_wdata;
        REG_DIR_X:   dir_x_r   <= cfg_wdata[18:0];
        REG_DIR_Y:   dir_y_r   <= cfg_wdata[18:0];
        REG_PLANE_X: plane_x_r <= cfg_wdata[18:0];
        REG_PLANE_Y: plane_y_r <= cfg_wdata[18:0];
        default: ;
      endcase
    end
  end

  assign mag_x = ray_x_r[29] ? 30'(-ray_x_r) : 30'(ray_x_r);
  assign mag_y = ray_y_r[29] ? 30'(-ray_y_r) : 30'(ray_y_r);
  assign frac_x = ray_x_r[29] ? {1'b0, pos_x_r[15:0]} : 17'h10000 - {1'b0, pos_x_r[15:0]};
  assign frac_y = ray_y_r[29] ? {1'b0, pos_y_r[15:0]} : 17'h10000 - {1'b0, pos_y_r[15:0]};
  assign perp_sat = (perp_r > 40'hFF_FFFF) ? 24'hFF_FFFF : perp_r[23:0];

  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd)
      CMD_DIV_X: begin
        div_num = {1'b1, 32'b0};
        div_den = {2'b0, mag_x};
      end
      CMD_DIV_Y: begin
        div_num = {1'b1, 32'b0};
        div_den = {2'b0, mag_y};
      end
      CMD_LINE_DIV: begin
        div_num = DIV_W'(SCREEN_HEIGHT) << 16;
        div_den = {8'b0, perp_sat};
      end
      default: div_start = 1'b0;
    endcase
  end

  grd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      CMD_MUL_X: begin
        mul_a = 20'(plane_x_r);
        mul_b = 33'(cam_r);
      end
      CMD_MUL_Y: begin
        mul_a = 20'(plane_y_r);
        mul_b = 33'(cam_r);
      end
      CMD_MUL_SX: begin
        mul_a = $signed({3'b0, frac_x});
        mul_b = $signed({1'b0, dx_r});
      end
      CMD_MUL_SY: begin
        mul_a = $signed({3'b0, frac_y});
        mul_b = $signed({1'b0, dy_r});
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_adj  = prod_r + (prod_r[52] ? 53'sd65535 : 53'sd0);
    dir_sel   = (cmd == CMD_RAY_X) ? dir_x_r : dir_y_r;
    ray_new   = 30'(dir_sel) + $signed(prod_adj[45:16]);
    mag_sel   = (cmd == CMD_DX_SET) ? mag_x : mag_y;
    delta_new = (mag_sel == '0 || div_quo[32]) ? 32'hFFFF_FFFF : div_quo[31:0];
  end

  always_comb begin
    take_x = side_x_r < side_y_r;
    nx     = ray_x_r[29] ? mx_r - CELL_W'(1) : mx_r + CELL_W'(1);
    ny     = ray_y_r[29] ? my_r - CELL_W'(1) : my_r + CELL_W'(1);
    if (take_x) begin
      step_leave = ray_x_r[29] ? (mx_r == '0) : ({1'b0, mx_r} == GD_LAST);
      rd_addr    = {my_r, nx};
    end else begin
      step_leave = ray_y_r[29] ? (my_r == '0) : ({1'b0, my_r} == GD_LAST);
      rd_addr    = {ny, mx_r};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd)
      CMD_LOAD: begin
        col_r <= in_col;
        cam_r <= $signed({1'b0, cam_prod[46:20]}) - 28'sd65536;
      end
      CMD_RAY_X:   ray_x_r <= ray_new;
      CMD_RAY_Y:   ray_y_r <= ray_new;
      CMD_DX_SET:  dx_r    <= delta_new;
      CMD_DY_SET:  dy_r    <= delta_new;
      CMD_SX_SET: begin
        side_x_r <= {7'b0, prod_r[48:16]};
        mx_r     <= pos_x_r[20:16];
        my_r     <= pos_y_r[20:16];
        side_r   <= 1'b0;
        perp_r   <= '0;
        steps_r  <= '0;
        hit_r    <= 1'b0;
        leave_r  <= 1'b0;
      end
      CMD_SY_SET: side_y_r <= {7'b0, prod_r[48:16]};
      CMD_STEP: begin
        steps_r <= steps_r + STEP_W'(1);
        leave_r <= step_leave;
        if (take_x) begin
          side_x_r <= side_x_r + {8'b0, dx_r};
          perp_r   <= side_x_r;
          side_r   <= 1'b0;
          if (!step_leave) begin
            mx_r <= nx;
          end
        end else begin
          side_y_r <= side_y_r + {8'b0, dy_r};
          perp_r   <= side_y_r;
          side_r   <= 1'b1;
          if (!step_leave) begin
            my_r <= ny;
          end
        end
      end
      CMD_CHECK: hit_r <= !leave_r && map_rd_r;
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_bit  = 1'b0;
    wr_addr = clr_addr_r;
    if (cmd == CMD_CLR) begin
      wr_en = 1'b1;
    end else if (cmd == CMD_WRITE) begin
      wr_en   = ({1'b0, in_cx} < GD) && ({1'b0, in_cy} < GD);
      wr_bit  = in_wall;
      wr_addr = {in_cy, in_cx};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_bit;
    end
    map_rd_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd == CMD_CLR) begin
      clr_addr_r <= clr_addr_r + MAP_AW'(1);
    end
  end

  always_comb begin
    line    = (perp_r == '0) ? 32'hFFFF_FFFF : div_quo[31:0];
    half    = line[31:1];
    start_d = 31'(HALF_H) - half;
    end_s   = 31'(HALF_H) + half;
    row_top = (half >= 31'(HALF_H)) ? 10'd0 : start_d[9:0];
    row_bot = (half >= 31'(REST_H)) ? 10'(SCREEN_HEIGHT - 1) : end_s[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_FINISH) begin
      out_data_r <= OUT_DATA_W'({my_r, mx_r, perp_sat, side_r, row_bot, row_top, col_r});
      out_user_r <= !hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    status.is_cast    = in_tuser;
    status.clr_last   = (clr_addr_r == MAP_AW'(MAP_DEPTH - 1));
    status.div_done   = div_done;
    status.cam_out    = ({1'b0, pos_x_r[20:16]} >= GD) || ({1'b0, pos_y_r[20:16]} >= GD);
    status.leave      = leave_r;
    status.hit_bit    = map_rd_r;
    status.steps_done = (steps_r == STEP_W'(STEP_LIMIT));
    status.perp_zero  = (perp_r == '0);
    status.out_free   = !out_valid_r || out_tready;
  end

endmodule

### sv/grd_ctrl.sv
module grd_ctrl import grd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  dp_status_t status,
  output logic       in_tready,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL_X, S_RAY_X, S_MUL_Y, S_RAY_Y,
    S_DIV_X, S_DX_WAIT, S_DIV_Y, S_DY_WAIT, S_MUL_SX, S_SX_SET,
    S_MUL_SY, S_SY_SET, S_STEP, S_CHECK, S_LINE, S_LINE_WAIT, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd = CMD_CLR;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (status.is_cast) begin
            cmd       = CMD_LOAD;
            state_nxt = S_MUL_X;
          end else begin
            cmd = CMD_WRITE;
          end
        end
      end
      S_MUL_X: begin
        cmd       = CMD_MUL_X;
        state_nxt = S_RAY_X;
      end
      S_RAY_X: begin
        cmd       = CMD_RAY_X;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd       = CMD_MUL_Y;
        state_nxt = S_RAY_Y;
      end
      S_RAY_Y: begin
        cmd       = CMD_RAY_Y;
        state_nxt = S_DIV_X;
      end
      S_DIV_X: begin
        cmd       = CMD_DIV_X;
        state_nxt = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (status.div_done) begin
          cmd       = CMD_DX_SET;
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        cmd       = CMD_DIV_Y;
        state_nxt = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (status.div_done) begin
          cmd       = CMD_DY_SET;
          state_nxt = S_MUL_SX;
        end
      end
      S_MUL_SX: begin
        cmd       = CMD_MUL_SX;
        state_nxt = S_SX_SET;
      end
      S_SX_SET: begin
        cmd       = CMD_SX_SET;
        state_nxt = S_MUL_SY;
      end
      S_MUL_SY: begin
        cmd       = CMD_MUL_SY;
        state_nxt = S_SY_SET;
      end
      S_SY_SET: begin
        cmd       = CMD_SY_SET;
        state_nxt = status.cam_out ? S_LINE : S_STEP;
      end
      S_STEP: begin
        cmd       = CMD_STEP;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd = CMD_CHECK;
        if (status.leave || status.hit_bit || status.steps_done) begin
          state_nxt = S_LINE;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_LINE: begin
        if (status.perp_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_LINE_DIV;
          state_nxt = S_LINE_WAIT;
        end
      end
      S_LINE_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd       = CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

### sv/grid_dda_raycaster.sv
// Grid raycaster. Input words on in_* carry either a map cell write or a cast
// request for one screen column, selected by in_tuser. A map write is done in
// the idle state and gives no output word. A cast gives one output word on
// out_* with the wall span, side, perpendicular distance, hit cell and an
// escape flag. Each DDA step of the ray reads the map memory, and a ray takes
// at most 66 steps. One shared radix-2 divider serves each cast up to three
// times: for the two step lengths and, unless the distance is zero, for the
// line height.
// Camera registers are written through cfg_*; the user must write them only
// while the block is idle, which the block itself does not enforce. After reset
// the map memory is cleared one cell per cycle; in_tready stays low during
// that pass, while configuration writes are taken throughout.
// The output word sits in a register. If the receiver stalls, the block
// still takes the next input word and works on it; it then holds before
// presenting its own result until the register is free.
module grid_dda_raycaster import grd_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int GRID_DIM      = DEF_GRID_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // column[9:0], cell_x[14:10], cell_y[19:15], wall[20], zeros above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_column[9:0], first row[19:10], last row[29:20], hit_side[30],
  // perp_distance[54:31], hit_x[59:55], hit_y[64:60], zeros above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // escaped[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t       cmd;
  dp_status_t status;

  grd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  grd_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GRID_DIM      (GRID_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### sim/tb_grid_dda_raycaster.sv
`timescale 1ns / 100ps

module tb_grid_dda_raycaster;

  localparam int SCR_W = grd_pkg::DEF_SCREEN_WIDTH;
  localparam int SCR_H = grd_pkg::DEF_SCREEN_HEIGHT;
  localparam int GRID = grd_pkg::DEF_GRID_DIM;
  localparam logic OP_MAP_WRITE = 1'b0;
  localparam logic OP_CAST = 1'b1;
  localparam longint ONE = 65536;
  localparam longint unsigned STEP_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned DIST_MAX = 64'hFF_FFFF;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [9:0] column;
    logic [9:0] row_top;
    logic [9:0] row_bot;
    logic hit_side;
    logic [23:0] perp_distance;
    logic [4:0] hit_x;
    logic [4:0] hit_y;
    logic escaped;
  } wall_span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [grd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [grd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [grd_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [grd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  grid_dda_raycaster dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the camera and the wall map.
  bit map_bits [0:1023];
  longint unsigned cam_pos_x, cam_pos_y;
  longint cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;

  wall_span_t expected_spans [$];
  int error_count = 0;
  int casts_sent = 0, writes_sent = 0, spans_seen = 0, escapes_seen = 0, zero_dist_seen = 0;
  int sender_idle_pct = 0, rx_stall_pct = 0;
  bit rx_hold = 1'b0;

  function automatic longint sext19(logic [20:0] v);
    return longint'(signed'(v[18:0]));
  endfunction

  function automatic longint unsigned step_length(longint r);
    longint unsigned m, d;
    m = (r < 0) ? longint'(-r) : r;
    if (m == 0) return STEP_MAX;
    d = (64'd1 << 32) / m;
    return (d > STEP_MAX) ? STEP_MAX : d;
  endfunction

  function automatic longint unsigned first_side(longint unsigned p, longint r,
                                                 longint unsigned d);
    longint unsigned frac;
    frac = p & 64'hFFFF;
    if (r >= 0) frac = ONE - frac;
    return (frac * d) >> 16;
  endfunction

  function automatic wall_span_t trace_column(logic [9:0] col);
    wall_span_t s;
    longint cam, ray_x, ray_y, mx, my, sx, sy, nx, ny, st, en;
    longint unsigned dx, dy, side_x, side_y, perp, line;
    int side, esc, steps;
    bit hit;
    perp = 0; side = 0; esc = 0; hit = 0;
    cam = longint'((64'd2 * longint'(col) * ONE) / SCR_W) - ONE;
    ray_x = cam_dir_x + (cam_plane_x * cam) / ONE;
    ray_y = cam_dir_y + (cam_plane_y * cam) / ONE;
    mx = longint'(cam_pos_x >> 16);
    my = longint'(cam_pos_y >> 16);
    dx = step_length(ray_x);
    dy = step_length(ray_y);
    sx = (ray_x < 0) ? -1 : 1;
    sy = (ray_y < 0) ? -1 : 1;
    side_x = first_side(cam_pos_x, ray_x, dx);
    side_y = first_side(cam_pos_y, ray_y, dy);
    if (mx >= GRID || my >= GRID) begin
      esc = 1;
    end else begin
      for (steps = 0; steps < 2 * GRID + 2 && !hit; steps++) begin
        nx = mx; ny = my;
        if (side_x < side_y) begin
          side_x += dx; nx += sx; side = 0; perp = side_x - dx;
        end else begin
          side_y += dy; ny += sy; side = 1; perp = side_y - dy;
        end
        if (nx < 0 || nx >= GRID || ny < 0 || ny >= GRID) begin
          esc = 1;
          break;
        end
        mx = nx; my = ny;
        if (map_bits[my * 32 + mx]) hit = 1;
      end
      if (!hit) esc = 1;
    end
    if (perp > DIST_MAX) perp = DIST_MAX;
    line = (perp == 0) ? STEP_MAX : ((longint'(SCR_H) << 16) / perp);
    if (line > STEP_MAX) line = STEP_MAX;
    st = SCR_H / 2 - longint'(line / 2);
    en = SCR_H / 2 + longint'(line / 2);
    if (st < 0) st = 0;
    if (en >= SCR_H) en = SCR_H - 1;
    s.column = col;
    s.row_top = st[9:0];
    s.row_bot = en[9:0];
    s.hit_side = side[0];
    s.perp_distance = perp[23:0];
    s.hit_x = mx[4:0];
    s.hit_y = my[4:0];
    s.escaped = esc[0];
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_word(logic op, logic [9:0] col, logic [4:0] cx, logic [4:0] cy,
                           logic wall);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, wall, cy, cx, col};
    do @(posedge clk); while (!in_tready);
    if (op == OP_CAST) begin
      expected_spans.push_back(trace_column(col));
      casts_sent++;
    end else begin
      map_bits[cy * 32 + cx] = wall;
      writes_sent++;
    end
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [grd_pkg::CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[20:0];
    @(posedge clk);
    case (idx)
      grd_pkg::REG_POS_X: cam_pos_x = val & 64'h1F_FFFF;
      grd_pkg::REG_POS_Y: cam_pos_y = val & 64'h1F_FFFF;
      grd_pkg::REG_DIR_X: cam_dir_x = sext19(val[20:0]);
      grd_pkg::REG_DIR_Y: cam_dir_y = sext19(val[20:0]);
      grd_pkg::REG_PLANE_X: cam_plane_x = sext19(val[20:0]);
      grd_pkg::REG_PLANE_Y: cam_plane_y = sext19(val[20:0]);
      default: ;
    endcase
  endtask

  task automatic set_camera(longint px, longint py, longint dx, longint dy, longint qx,
                            longint qy);
    wait_idle();
    write_reg(grd_pkg::REG_POS_X, px);
    write_reg(grd_pkg::REG_POS_Y, py);
    write_reg(grd_pkg::REG_DIR_X, dx);
    write_reg(grd_pkg::REG_DIR_Y, dy);
    write_reg(grd_pkg::REG_PLANE_X, qx);
    write_reg(grd_pkg::REG_PLANE_Y, qy);
    cfg_we <= 1'b0;
  endtask

  function automatic longint pick_vector();
    case ($urandom_range(5))
      0: return -131072;
      1: return 131072;
      2: return 0;
      default: return longint'($urandom_range(262144)) - 131072;
    endcase
  endfunction

  function automatic longint pick_pos();
    case ($urandom_range(5))
      0: return 0;
      1: return 2097151;
      default: return $urandom_range(2097151);
    endcase
  endfunction

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      wall_span_t want;
      spans_seen++;
      if (out_tuser) escapes_seen++;
      if (out_tdata[54:31] == 0) zero_dist_seen++;
      if (expected_spans.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_spans.pop_front();
        if (out_tdata[9:0] != want.column)
          report_mismatch("column", out_tdata[9:0], want.column);
        if (out_tdata[19:10] != want.row_top)
          report_mismatch("top row", out_tdata[19:10], want.row_top);
        if (out_tdata[29:20] != want.row_bot)
          report_mismatch("bottom row", out_tdata[29:20], want.row_bot);
        if (out_tdata[30] != want.hit_side)
          report_mismatch("hit_side", out_tdata[30], want.hit_side);
        if (out_tdata[54:31] != want.perp_distance)
          report_mismatch("perp_distance", out_tdata[54:31], want.perp_distance);
        if (out_tdata[59:55] != want.hit_x)
          report_mismatch("hit_x", out_tdata[59:55], want.hit_x);
        if (out_tdata[64:60] != want.hit_y)
          report_mismatch("hit_y", out_tdata[64:60], want.hit_y);
        if (out_tuser != want.escaped)
          report_mismatch("escaped", out_tuser, want.escaped);
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic test_reset_camera();
    send_word(OP_CAST, 10'd0, 5'd31, 5'd31, 1'b1);
    send_word(OP_CAST, 10'd320, 5'd0, 5'd0, 1'b0);
    send_word(OP_CAST, 10'd639, 5'd0, 5'd0, 1'b0);
    send_word(OP_CAST, 10'd1023, 5'd0, 5'd0, 1'b0);
    end_burst();
  endtask

  task automatic test_directed_walls();
    // The camera sits exactly on a cell boundary looking back at a wall,
    // which gives a zero distance and the full screen span.
    set_camera(5 * ONE, 7 * ONE + 32768, -65536, 0, 0, 43253);
    send_word(OP_MAP_WRITE, 10'h3FF, 5'd4, 5'd7, 1'b1);
    send_word(OP_CAST, 10'd320, 5'd0, 5'd0, 1'b0);
    send_word(OP_MAP_WRITE, 10'd0, 5'd31, 5'd31, 1'b1);
    send_word(OP_MAP_WRITE, 10'd0, 5'd0, 5'd0, 1'b1);
    send_word(OP_MAP_WRITE, 10'd0, 5'd4, 5'd7, 1'b0);
    send_word(OP_CAST, 10'd320, 5'd0, 5'd0, 1'b0);
    send_word(OP_CAST, 10'd0, 5'd0, 5'd0, 1'b0);
    end_burst();
    // Zero ray on both axes: ties step along y.
    set_camera(16 * ONE + 100, 16 * ONE + 100, 0, 0, 0, 0);
    send_word(OP_CAST, 10'd517, 5'd0, 5'd0, 1'b0);
    end_burst();
    set_camera(2097151, 2097151, 131072, 131072, 131072, -131072);
    send_word(OP_CAST, 10'd0, 5'd0, 5'd0, 1'b0);
    send_word(OP_CAST, 10'd1023, 5'd0, 5'd0, 1'b0);
    end_burst();
    set_camera(0, 0, -131072, -131072, -131072, 131072);
    send_word(OP_MAP_WRITE, 10'd0, 5'd0, 5'd1, 1'b1);
    send_word(OP_CAST, 10'd0, 5'd0, 5'd0, 1'b0);
    send_word(OP_CAST, 10'd700, 5'd0, 5'd0, 1'b0);
    end_burst();
    set_camera(20 * ONE + 12345, 3 * ONE, 65536, 26000, 30000, -43253);
    send_word(OP_MAP_WRITE, 10'd0, 5'd25, 5'd5, 1'b1);
    send_word(OP_CAST, 10'd100, 5'd0, 5'd0, 1'b0);
    send_word(OP_CAST, 10'd640, 5'd0, 5'd0, 1'b0);
    end_burst();
  endtask

  task automatic test_random_scenes();
    for (int phase = 0; phase < 12; phase++) begin
      case (phase / 4)
        0: begin sender_idle_pct = 6; rx_stall_pct = 85; end
        1: begin sender_idle_pct = 85; rx_stall_pct = 6; end
        default: begin sender_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      set_camera(pick_pos(), pick_pos(), pick_vector(), pick_vector(), pick_vector(),
                 pick_vector());
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(99) < 45)
          send_word(OP_MAP_WRITE, 10'($urandom), 5'($urandom), 5'($urandom),
                    $urandom_range(99) < 35);
        else
          send_word(OP_CAST, 10'($urandom), 5'($urandom), 5'($urandom), 1'($urandom));
        if ($urandom_range(29) == 0) end_burst();
      end
      end_burst();
    end
  endtask

  task automatic test_output_stall();
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    set_camera(16 * ONE, 16 * ONE, 65536, 0, 0, 43253);
    fork
      begin
        rx_hold = 1'b1;
        repeat (4000) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int n = 0; n < 12; n++) send_word(OP_CAST, 10'($urandom), 5'd0, 5'd0, 1'b0);
    end_burst();
  endtask

  initial begin
    cam_pos_x = 0; cam_pos_y = 0;
    cam_dir_x = 65536; cam_dir_y = 0;
    cam_plane_x = 0; cam_plane_y = 43253;
    foreach (map_bits[i]) map_bits[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_camera();
    test_directed_walls();
    test_random_scenes();
    test_output_stall();
    wait_idle();
    $display("Sent %0d casts and %0d map writes; %0d spans checked.", casts_sent,
             writes_sent, spans_seen);
    $display("Rays that escaped the grid: %0d; zero-distance hits: %0d.", escapes_seen,
             zero_dist_seen);
    if (error_count == 0 && expected_spans.size() == 0) begin
      $display("tb_grid_dda_raycaster: clean");
    end else begin
      $display("tb_grid_dda_raycaster: errors");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timed out with %0d spans outstanding.", expected_spans.size());
    $display("tb_grid_dda_raycaster: errors");
    $finish;
  end

endmodule

### grid_dda_raycaster.f
sv/grd_pkg.sv
sv/grd_div.sv
sv/grd_dp.sv
sv/grd_ctrl.sv
sv/grid_dda_raycaster.sv
sim/tb_grid_dda_raycaster.sv
